### sv/trm_pkg.sv
// shared constants and codes for the tiny register machine execute block
package trm_pkg;

    localparam int DATA_W        = 32;
    localparam int NUM_REGS      = 26;
    localparam int REG_ADDR_W    = $clog2(NUM_REGS);
    localparam int PC_W          = 11;
    localparam int PROGRAM_DEPTH = 1024;
    localparam int TARGET_W      = 10;
    localparam int OP_W          = 3;
    localparam int CMD_W         = 2;
    localparam int DIV_CNT_W     = $clog2(DATA_W + 1);

    // statement kinds
    localparam logic [CMD_W-1:0] CMD_ASSIGN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_JUMP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PRINT  = 2'd2;

    // assign operations
    localparam logic [OP_W-1:0] OP_COPY = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

    // jump relations
    localparam logic [OP_W-1:0] REL_EQ = 3'd0;
    localparam logic [OP_W-1:0] REL_GT = 3'd1;
    localparam logic [OP_W-1:0] REL_LT = 3'd2;
    localparam logic [OP_W-1:0] REL_NE = 3'd3;
    localparam logic [OP_W-1:0] REL_LE = 3'd4;
    localparam logic [OP_W-1:0] REL_GE = 3'd5;

    // request from the execute control to the divider
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    // answer from the divider
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

### sv/tiny_register_machine_execute.sv
// top level: executes one decoded statement per item against a 26-entry register memory
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | decoded statement (tdata, tuser)
//  m_      | out | m_tvalid/m_tready  | next pc, halted, print value, flags (tdata)
//  cfg_    | in  | cfg_valid/cfg_ready| program_length write (cfg_data)
//
//  one item at a time: copy, add, sub, mul, jump and print go through fetch, exec and done,
//  and a divide also waits in the div state on the bit-serial divider
//  register memory is read into registers at accept; the write-back lands before the next accept
//  reset clears pc, program_length and the register valid bits, so all registers read as zero
//  a result waiting on m_tready holds the block in its write-back cycle
module tiny_register_machine_execute
(
    input  logic                     clk,
    input  logic                     rst_n,
    // tdata: operation[2:0], dest_index[7:3], first_operand[39:8], second_operand[71:40],
    //        target_line[81:72], newline_after[82], zero fill [87:83]
    input  logic [87:0]              s_tdata,
    // tuser: cmd[1:0], first_is_register[2], second_is_register[3]
    input  logic [3:0]               s_tuser,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // tdata: next_pc[10:0], halted[11], print_valid[12], print_value[44:13],
    //        print_newline[45], divide_by_zero[46], zero fill [47]
    output logic [47:0]              m_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [trm_pkg::PC_W-1:0] cfg_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam int DW = trm_pkg::DATA_W;
    localparam int AW = trm_pkg::REG_ADDR_W;
    localparam int PW = trm_pkg::PC_W;

    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;
    logic [PW-1:0]                pc_reg;
    logic [PW-1:0]                prog_len_reg;
    logic [trm_pkg::NUM_REGS-1:0] rf_valid_reg;
    logic [DW-1:0]                rf_mem [trm_pkg::NUM_REGS];

    // input fields
    logic [trm_pkg::CMD_W-1:0]    in_cmd;
    logic [trm_pkg::OP_W-1:0]     in_op;
    logic [4:0]                   in_dest;
    logic                         in_a_is_reg;
    logic [DW-1:0]                in_a;
    logic                         in_b_is_reg;
    logic [DW-1:0]                in_b;
    logic [trm_pkg::TARGET_W-1:0] in_target;
    logic                         in_nl;
    logic                         in_acc;

    // captured statement
    logic [trm_pkg::CMD_W-1:0]    cmd_reg;
    logic [trm_pkg::OP_W-1:0]     op_reg;
    logic [4:0]                   dest_reg;
    logic                         a_is_reg_reg;
    logic [DW-1:0]                a_imm_reg;
    logic                         b_is_reg_reg;
    logic [DW-1:0]                b_imm_reg;
    logic [trm_pkg::TARGET_W-1:0] target_reg;
    logic                         nl_reg;
    logic                         halt_reg;

    // register memory read side
    logic [AW-1:0]                addr_a;
    logic [AW-1:0]                addr_b;
    logic                         ok_a;
    logic                         ok_b;
    logic [DW-1:0]                rd_a_reg;
    logic [DW-1:0]                rd_b_reg;
    logic                         ok_a_reg;
    logic                         ok_b_reg;

    // execute
    logic [DW-1:0]                a_reg;
    logic [DW-1:0]                b_reg;
    logic [DW-1:0]                res_reg;
    logic [PW-1:0]                npc_reg;
    logic                         dz_reg;
    logic [PW-1:0]                pc_inc;
    logic                         taken;
    logic                         finish;
    logic                         rf_we;
    logic                         dest_ok;

    // output register
    logic                         out_valid_reg;
    logic [47:0]                  out_data_reg;

    trm_pkg::div_req_t            div_req;
    trm_pkg::div_rsp_t            div_rsp;

    assign in_op       = s_tdata[2:0];
    assign in_dest     = s_tdata[7:3];
    assign in_a        = s_tdata[39:8];
    assign in_b        = s_tdata[71:40];
    assign in_target   = s_tdata[81:72];
    assign in_nl       = s_tdata[82];
    assign in_cmd      = s_tuser[1:0];
    assign in_a_is_reg = s_tuser[2];
    assign in_b_is_reg = s_tuser[3];

    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // port a also serves the printed register
    always_comb
    begin
        if (in_cmd == trm_pkg::CMD_PRINT)
        begin
            addr_a = in_dest[AW-1:0];
            ok_a   = (in_dest < 5'(trm_pkg::NUM_REGS));
        end
        else
        begin
            addr_a = in_a[AW-1:0];
            ok_a   = (in_a[DW-1:AW] == '0) && (in_a[AW-1:0] < AW'(trm_pkg::NUM_REGS));
        end
        addr_b = in_b[AW-1:0];
        ok_b   = (in_b[DW-1:AW] == '0) && (in_b[AW-1:0] < AW'(trm_pkg::NUM_REGS));
    end

    assign dest_ok = (dest_reg < 5'(trm_pkg::NUM_REGS));
    assign finish  = (state_reg == S_DONE) && (!out_valid_reg || m_tready);
    assign rf_we   = finish && !halt_reg && (cmd_reg == trm_pkg::CMD_ASSIGN) && dest_ok;

    // register memory, two read ports and one write port
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[dest_reg[AW-1:0]] <= res_reg;
        end
        if (in_acc)
        begin
            rd_a_reg <= rf_mem[addr_a];
            rd_b_reg <= rf_mem[addr_b];
        end
    end

    // a register never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
        end
        else if (rf_we)
        begin
            rf_valid_reg[dest_reg[AW-1:0]] <= 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (!halt_reg && (cmd_reg == trm_pkg::CMD_ASSIGN)
                    && (op_reg == trm_pkg::OP_DIV) && (b_reg != '0))
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pc_reg       <= '0;
            prog_len_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                prog_len_reg <= (cfg_data > PW'(trm_pkg::PROGRAM_DEPTH))
                                ? PW'(trm_pkg::PROGRAM_DEPTH) : cfg_data;
            end
            if (finish && !halt_reg)
            begin
                pc_reg <= npc_reg;
            end
        end
    end

    // statement capture at accept
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg      <= in_cmd;
            op_reg       <= in_op;
            dest_reg     <= in_dest;
            a_is_reg_reg <= in_a_is_reg;
            a_imm_reg    <= in_a;
            b_is_reg_reg <= in_b_is_reg;
            b_imm_reg    <= in_b;
            target_reg   <= in_target;
            nl_reg       <= in_nl;
            halt_reg     <= (pc_reg >= prog_len_reg);
            ok_a_reg     <= ok_a && rf_valid_reg[addr_a];
            ok_b_reg     <= ok_b && rf_valid_reg[addr_b];
        end
    end

    // operand select once the memory data is back
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FETCH)
        begin
            if (cmd_reg == trm_pkg::CMD_PRINT || a_is_reg_reg)
            begin
                a_reg <= ok_a_reg ? rd_a_reg : '0;
            end
            else
            begin
                a_reg <= a_imm_reg;
            end
            b_reg <= b_is_reg_reg ? (ok_b_reg ? rd_b_reg : '0) : b_imm_reg;
        end
    end

    assign pc_inc = pc_reg + 1'b1;

    always_comb
    begin
        case (op_reg)
            trm_pkg::REL_EQ: taken = (a_reg == b_reg);
            trm_pkg::REL_GT: taken = ($signed(a_reg) > $signed(b_reg));
            trm_pkg::REL_LT: taken = ($signed(a_reg) < $signed(b_reg));
            trm_pkg::REL_NE: taken = (a_reg != b_reg);
            trm_pkg::REL_LE: taken = ($signed(a_reg) <= $signed(b_reg));
            trm_pkg::REL_GE: taken = ($signed(a_reg) >= $signed(b_reg));
            default:         taken = 1'b0;
        endcase
    end

    // alu, multiplier result registered straight into res_reg
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EXEC)
        begin
            npc_reg <= (cmd_reg == trm_pkg::CMD_JUMP && taken) ? PW'(target_reg) : pc_inc;
            case (op_reg)
                trm_pkg::OP_ADD: res_reg <= a_reg + b_reg;
                trm_pkg::OP_SUB: res_reg <= a_reg - b_reg;
                trm_pkg::OP_MUL: res_reg <= a_reg * b_reg;
                trm_pkg::OP_DIV: res_reg <= '0;
                default:         res_reg <= a_reg;
            endcase
            dz_reg <= (cmd_reg == trm_pkg::CMD_ASSIGN) && (op_reg == trm_pkg::OP_DIV)
                      && (b_reg == '0);
        end
        else if (state_reg == S_DIV && div_rsp.done)
        begin
            res_reg <= div_rsp.quotient;
        end
    end

    assign div_req.start    = (state_reg == S_EXEC) && (state_next == S_DIV);
    assign div_req.dividend = a_reg;
    assign div_req.divisor  = b_reg;

    trm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            if (halt_reg)
            begin
                out_data_reg <= {36'd0, 1'b1, pc_reg};
            end
            else
            begin
                out_data_reg <= {1'b0,
                                 (cmd_reg == trm_pkg::CMD_ASSIGN) && dz_reg,
                                 (cmd_reg == trm_pkg::CMD_PRINT) && nl_reg,
                                 (cmd_reg == trm_pkg::CMD_PRINT) ? a_reg : {DW{1'b0}},
                                 cmd_reg == trm_pkg::CMD_PRINT,
                                 npc_reg >= prog_len_reg,
                                 npc_reg};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### sv/trm_div.sv
// signed 32-bit divider, one quotient bit per cycle, truncating toward zero
module trm_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  trm_pkg::div_req_t req,
    output trm_pkg::div_rsp_t rsp
);

    logic                            busy_reg;
    logic [trm_pkg::DIV_CNT_W-1:0]   count_reg;
    logic                            neg_reg;
    logic [trm_pkg::DATA_W-1:0]      quot_reg;
    logic [trm_pkg::DATA_W-1:0]      rem_reg;
    logic [trm_pkg::DATA_W-1:0]      dsr_reg;
    logic [trm_pkg::DATA_W:0]        rem_shift;
    logic [trm_pkg::DATA_W:0]        rem_sub;
    logic                            a_neg;
    logic                            b_neg;

    assign a_neg     = req.dividend[trm_pkg::DATA_W-1];
    assign b_neg     = req.divisor[trm_pkg::DATA_W-1];
    assign rem_shift = {rem_reg, quot_reg[trm_pkg::DATA_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= trm_pkg::DIV_CNT_W'(trm_pkg::DATA_W);
        end
        else if (busy_reg)
        begin
            if (count_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // restoring steps on magnitudes
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg  <= a_neg ^ b_neg;
            quot_reg <= a_neg ? (-req.dividend) : req.dividend;
            dsr_reg  <= b_neg ? (-req.divisor) : req.divisor;
            rem_reg  <= '0;
        end
        else if (busy_reg && (count_reg != '0))
        begin
            if (!rem_sub[trm_pkg::DATA_W])
            begin
                rem_reg  <= rem_sub[trm_pkg::DATA_W-1:0];
                quot_reg <= {quot_reg[trm_pkg::DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift[trm_pkg::DATA_W-1:0];
                quot_reg <= {quot_reg[trm_pkg::DATA_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done     = busy_reg && (count_reg == '0);
    assign rsp.quotient = neg_reg ? (-quot_reg) : quot_reg;

endmodule
